// ----- rtl/core/dembd_pkg.sv -----
// shared types and constants of the delay embedding streamer
`timescale 1ns / 1ps
`default_nettype none

package dembd_pkg;

  // field widths fixed by the stream format
  localparam int VALUE_W    = 34;
  localparam int SAMPLE_W   = 32;
  localparam int COL_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  // sqrt(2) in Q2.30, rounded to nearest
  localparam logic [SAMPLE_W-1:0] SQRT2_Q30 = 32'd1518500250;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DIMENSION = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPACING   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 2'd2;

  // configuration reset values
  localparam logic [4:0] DIMENSION_RESET = 5'd2;
  localparam logic [6:0] SPACING_RESET   = 7'd1;
  localparam logic       MODE_RESET      = 1'b1;

  // one emitted row value
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COL_W-1:0]          column_index;
    logic                      row_end;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/dembd_combine.sv -----
// sample combiner: sqrt2*x - y or x alone, registered product
`timescale 1ns / 1ps
`default_nettype none

module dembd_combine
  import dembd_pkg::*;
(
  input  logic                       clk,
  input  logic                       load,
  input  logic signed [SAMPLE_W-1:0] x_sample,
  input  logic signed [SAMPLE_W-1:0] y_sample,
  input  logic                       mode,
  output logic signed [VALUE_W-1:0]  value
);

  logic signed [2*SAMPLE_W-1:0] prod;
  logic signed [SAMPLE_W-1:0]   x_q;
  logic signed [SAMPLE_W-1:0]   y_q;
  logic                         mode_q;
  logic signed [SAMPLE_W:0]     scaled;

  // product register, loaded on the input transfer
  always_ff @(posedge clk) begin
    if (load) begin
      prod   <= (2*SAMPLE_W)'(x_sample) * (2*SAMPLE_W)'($signed(SQRT2_Q30));
      x_q    <= x_sample;
      y_q    <= y_sample;
      mode_q <= mode;
    end
  end

  // arithmetic shift by 30 floors toward minus infinity
  assign scaled = prod[62:30];

  // subtract y or pass x
  always_comb begin
    if (mode_q) begin
      value = {scaled[SAMPLE_W], scaled} - {{2{y_q[SAMPLE_W-1]}}, y_q};
    end else begin
      value = {{2{x_q[SAMPLE_W-1]}}, x_q};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dembd_ring.sv -----
// sample ring memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module dembd_ring
  import dembd_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic signed [VALUE_W-1:0]  wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic signed [VALUE_W-1:0]  rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dembd_outq.sv -----
// two-entry output queue between ring reads and the result stream
`timescale 1ns / 1ps
`default_nettype none

module dembd_outq
  import dembd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  out_item_t  push_item,
  input  logic       pop,
  output logic       head_valid,
  output out_item_t  head_item,
  output logic [1:0] count
);

  out_item_t slot0;
  out_item_t slot1;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // slot data, slot0 is the head
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        slot1 <= push_item;
      end else begin
        slot0 <= push_item;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_item;
      end else begin
        slot1 <= push_item;
      end
    end
  end

  assign head_valid = (count != 2'd0);
  assign head_item  = slot0;

endmodule

`default_nettype wire

// ----- rtl/core/delay_embedding_streamer.sv -----
// delay embedding streamer top level: control, pointers and row sequencer
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata x_sample, y_sample; s_tuser start_of_series
//  m_*      out  m_tvalid/m_tready    m_tdata value, column_index; m_tlast row_end
//  cfg_*    in   cfg_valid/cfg_ready  cfg_addr register index, cfg_data write data
//
// an item is accepted in S_IDLE, where its product is formed, and written to the ring in
// S_WRITE; when a row is emitted, S_READ then issues one ring read per row value through
// the single read port
// reset clears the write pointer, fill count and configuration; the ring is not cleared
// a stalled sink fills the two-entry output queue and holds back further ring reads
`timescale 1ns / 1ps
`default_nettype none

module delay_embedding_streamer
  import dembd_pkg::*;
#(
  parameter int MAX_DIMENSION = 16,
  parameter int MAX_DELAY     = 64,
  parameter int RING_DEPTH    = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // x_sample[31:0], y_sample[63:32]
  input  logic                  s_tuser,   // start_of_series
  // row stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // value[33:0], column_index[37:34], zero
  output logic                  m_tlast,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
  localparam int TAU_W  = $clog2(MAX_DELAY + 1);
  localparam int COLC_W = $clog2(MAX_DIMENSION);
  localparam int SPAN_W = DIM_W + TAU_W;
  localparam int CW     = (SPAN_W > AW) ? SPAN_W : AW;
  localparam int PW     = ((AW > TAU_W) ? AW : TAU_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WRITE = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t state;

  logic [4:0] dim_reg;
  logic [6:0] tau_reg;
  logic       mode_reg;

  logic [DIM_W-1:0]  dim_eff;
  logic [TAU_W-1:0]  tau_eff;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] span_q;
  logic              span_ok_q;

  logic [AW-1:0] wp;
  logic [AW-1:0] fill;
  logic [AW-1:0] fill_next;
  logic          sos_q;

  logic [AW-1:0]     rd_ptr;
  logic [PW-1:0]     rd_diff;
  logic [AW-1:0]     rd_step;
  logic [COLC_W-1:0] col;
  logic              rd_issue;
  logic              rd_last;
  logic              credit_ok;

  logic             rv_q;
  logic [COL_W-1:0] col_q;
  logic             last_q;

  logic in_xfer;
  logic pop;
  logic emit;

  logic signed [VALUE_W-1:0] comb_value;
  logic signed [VALUE_W-1:0] ring_rdata;
  out_item_t                 push_item;
  out_item_t                 head_item;
  logic                      head_valid;
  logic [1:0]                q_cnt;

  // no transfer is taken while reset is held
  assign in_xfer   = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg  <= DIMENSION_RESET;
      tau_reg  <= SPACING_RESET;
      mode_reg <= MODE_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_DIMENSION: dim_reg  <= cfg_data[4:0];
        REG_SPACING:   tau_reg  <= cfg_data;
        REG_MODE:      mode_reg <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // clamp dimension and spacing into their legal ranges
  always_comb begin
    if (dim_reg == 5'd0) begin
      dim_eff = DIM_W'(1);
    end else if (int'(dim_reg) > MAX_DIMENSION) begin
      dim_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      dim_eff = DIM_W'(dim_reg);
    end
    if (tau_reg == 7'd0) begin
      tau_eff = TAU_W'(1);
    end else if (int'(tau_reg) > MAX_DELAY) begin
      tau_eff = TAU_W'(MAX_DELAY);
    end else begin
      tau_eff = TAU_W'(tau_reg);
    end
  end

  // row span, registered ahead of the write cycle
  assign span = SPAN_W'(dim_eff - DIM_W'(1)) * SPAN_W'(tau_eff);

  always_ff @(posedge clk) begin
    span_q    <= span;
    span_ok_q <= (CW'(span) < CW'(RING_DEPTH - 1));
  end

  // fill count for the current series, saturating
  always_comb begin
    if (sos_q) begin
      fill_next = AW'(1);
    end else if (fill < AW'(RING_DEPTH - 1)) begin
      fill_next = fill + AW'(1);
    end else begin
      fill_next = fill;
    end
  end

  assign emit = span_ok_q && (CW'(fill_next) > CW'(span_q));

  // read pointer steps back by the spacing, wrapping around the ring
  assign rd_diff = PW'(rd_ptr) - PW'(tau_eff);
  assign rd_step = rd_diff[PW-1] ? AW'(rd_diff + PW'(RING_DEPTH)) : AW'(rd_diff);

  // read credit: never more than the queue can hold
  assign pop       = m_tvalid && m_tready;
  assign credit_ok = ({1'b0, q_cnt} + {2'b00, rv_q}) < (3'd2 + {2'b00, pop});
  assign rd_issue  = (state == S_READ) && credit_ok;
  assign rd_last   = (DIM_W'(col) == dim_eff - DIM_W'(1));

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
      fill  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          fill <= fill_next;
          wp   <= (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + AW'(1);
          if (emit) begin
            state <= S_READ;
          end else begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (rd_issue && rd_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // start flag and row pointers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sos_q <= s_tuser;
    end
    if (state == S_WRITE) begin
      rd_ptr <= wp;
      col    <= '0;
    end else if (rd_issue) begin
      rd_ptr <= rd_step;
      col    <= col + COLC_W'(1);
    end
  end

  // read return tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      col_q  <= COL_W'(col);
      last_q <= rd_last;
    end
  end

  dembd_combine u_combine (
    .clk      (clk),
    .load     (in_xfer),
    .x_sample (s_tdata[31:0]),
    .y_sample (s_tdata[63:32]),
    .mode     (mode_reg),
    .value    (comb_value)
  );

  dembd_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (wp),
    .wdata (comb_value),
    .re    (rd_issue),
    .raddr (rd_ptr),
    .rdata (ring_rdata)
  );

  assign push_item.value        = ring_rdata;
  assign push_item.column_index = col_q;
  assign push_item.row_end      = last_q;

  dembd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (rv_q),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_cnt)
  );

  // result stream
  assign m_tvalid = head_valid;
  assign m_tdata  = {2'b00, head_item.column_index, head_item.value};
  assign m_tlast  = head_item.row_end;

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rv_q |-> (q_cnt != 2'd2 || pop))
    else $error("output queue overflow");

  a_last_read_ends_row: assert property (@(posedge clk) disable iff (rst)
    (rd_issue && rd_last) |=> (state == S_IDLE))
    else $error("row did not end after its last read");

  a_wp_in_range: assert property (@(posedge clk) disable iff (rst)
    (int'(wp) < RING_DEPTH) && (int'(fill) < RING_DEPTH))
    else $error("ring pointer or fill count out of range");

  a_write_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_WRITE))
    else $error("accepted sample not written");
`endif

endmodule

`default_nettype wire
